// ===== rtl/core/dqd_pkg.sv =====
// Shared types, constants and cell control codes for the indexed-delete deque.
package dqd_pkg;

    // List capacity and derived widths
    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 6;
    localparam int CMD_W = 2;
    localparam int ELEM_W = 32;
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Command codes; the spare code is ignored by the block
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

    typedef logic signed [ELEM_W-1:0] elem_t;

    // Input item
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        elem_t            value;
        logic [POS_W-1:0] position;
    } item_t;

    // Result item
    typedef struct packed {
        logic  direction;
        elem_t element;
        logic  list_empty;
        logic  end_of_direction;
        logic  last;
        logic  push_dropped;
    } result_t;

    // What every cell of the ring does this cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_DELETE,
        OP_ROT_FWD,
        OP_ROT_REV
    } cell_op_t;

    // Control broadcast along the ring
    typedef struct packed {
        cell_op_t         op;
        elem_t            value;
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/dqd_cell.sv =====
// One storage cell of the ring: holds a single list entry.
module dqd_cell (
    input  logic                      clk,
    input  logic [dqd_pkg::IDX_W-1:0] idx,
    input  dqd_pkg::cell_ctrl_t       ctrl,
    input  dqd_pkg::elem_t            left_entry,
    input  dqd_pkg::elem_t            right_entry,
    output dqd_pkg::elem_t            entry
);

    dqd_pkg::elem_t data_reg;
    dqd_pkg::elem_t data_next;
    logic [dqd_pkg::CMP_W-1:0] idx_ext;

    assign idx_ext = dqd_pkg::CMP_W'(idx);

    // Local decision from own index against the broadcast count and position
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            dqd_pkg::OP_PUSH_FRONT:
            begin
                data_next = (idx == '0) ? ctrl.value : left_entry;
            end
            dqd_pkg::OP_PUSH_BACK:
            begin
                if (idx_ext == dqd_pkg::CMP_W'(ctrl.count))
                begin
                    data_next = ctrl.value;
                end
            end
            dqd_pkg::OP_DELETE:
            begin
                if (idx_ext >= dqd_pkg::CMP_W'(ctrl.pos))
                begin
                    data_next = right_entry;
                end
            end
            dqd_pkg::OP_ROT_FWD: data_next = right_entry;
            dqd_pkg::OP_ROT_REV: data_next = left_entry;
            default:             data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign entry = data_reg;

endmodule

// ===== rtl/core/deque_indexed_delete_dump.sv =====
// Top level of the indexed-delete deque: command decode, ring of cells, dump sequencer.
// A command is applied to the ring in the cycle it is taken; the list is then dumped one
// result per cycle unless the result side stalls, front to back and back to front, by
// rotating the whole ring of DEPTH cells one place per result and reading the end cell.
// With n entries after the command, it yields 2n results (two list_empty results when the
// list is empty, none for the unused code) and takes no new command until the last is
// registered; that result sits in the output register while the next command is taken.
module deque_indexed_delete_dump (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  dqd_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output dqd_pkg::result_t result
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_FWD       = 5'b00010,
        S_REV       = 5'b00100,
        S_EMPTY_FWD = 5'b01000,
        S_EMPTY_REV = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [dqd_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [dqd_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        drop_reg, drop_next;
    logic                        result_valid_reg, result_valid_next;
    dqd_pkg::result_t            result_reg, result_next;

    dqd_pkg::cell_ctrl_t         ctrl;
    dqd_pkg::elem_t              ring [dqd_pkg::DEPTH];

    logic                        take;
    logic                        out_free;
    logic                        idx_last;
    logic                        full;
    logic                        pos_in_range;

    assign item_ready   = (state_reg == S_IDLE);
    assign take         = item_valid && item_ready;
    assign out_free     = !result_valid_reg || result_ready;
    assign idx_last     = (dqd_pkg::CNT_W'(idx_reg) + dqd_pkg::CNT_W'(1)) == count_reg;
    assign full         = (count_reg == dqd_pkg::CNT_W'(dqd_pkg::DEPTH));
    assign pos_in_range = dqd_pkg::CMP_W'(item.position) < dqd_pkg::CMP_W'(count_reg);

    // Ring of cells; neighbours wrap around at both ends
    for (genvar i = 0; i < dqd_pkg::DEPTH; i++)
    begin : g_cell
        localparam int LEFT  = (i + dqd_pkg::DEPTH - 1) % dqd_pkg::DEPTH;
        localparam int RIGHT = (i + 1) % dqd_pkg::DEPTH;

        dqd_cell u_cell (
            .clk         (clk),
            .idx         (dqd_pkg::IDX_W'(i)),
            .ctrl        (ctrl),
            .left_entry  (ring[LEFT]),
            .right_entry (ring[RIGHT]),
            .entry       (ring[i])
        );
    end

    // Command decode and dump sequencing
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        drop_next         = drop_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        ctrl.op           = dqd_pkg::OP_HOLD;
        ctrl.value        = item.value;
        ctrl.count        = count_reg;
        ctrl.pos          = item.position;

        case (state_reg)
            S_IDLE:
            begin
                if (take && item.cmd != dqd_pkg::CMD_UNUSED)
                begin
                    idx_next  = '0;
                    drop_next = 1'b0;
                    if (item.cmd == dqd_pkg::CMD_PUSH_FRONT || item.cmd == dqd_pkg::CMD_PUSH_BACK)
                    begin
                        if (full)
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.op    = (item.cmd == dqd_pkg::CMD_PUSH_FRONT) ?
                                         dqd_pkg::OP_PUSH_FRONT : dqd_pkg::OP_PUSH_BACK;
                            count_next = count_reg + dqd_pkg::CNT_W'(1);
                        end
                    end
                    else if (pos_in_range)
                    begin
                        ctrl.op    = dqd_pkg::OP_DELETE;
                        count_next = count_reg - dqd_pkg::CNT_W'(1);
                    end
                    state_next = (count_next == '0) ? S_EMPTY_FWD : S_FWD;
                end
            end
            S_FWD:
            begin
                if (out_free)
                begin
                    ctrl.op           = dqd_pkg::OP_ROT_FWD;
                    result_valid_next = 1'b1;
                    result_next       = '{direction: 1'b0, element: ring[0], list_empty: 1'b0,
                                          end_of_direction: idx_last, last: 1'b0,
                                          push_dropped: drop_reg};
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = S_REV;
                    end
                    else
                    begin
                        idx_next = idx_reg + dqd_pkg::IDX_W'(1);
                    end
                end
            end
            S_REV:
            begin
                if (out_free)
                begin
                    ctrl.op           = dqd_pkg::OP_ROT_REV;
                    result_valid_next = 1'b1;
                    result_next       = '{direction: 1'b1, element: ring[dqd_pkg::DEPTH-1],
                                          list_empty: 1'b0, end_of_direction: idx_last,
                                          last: idx_last, push_dropped: drop_reg};
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + dqd_pkg::IDX_W'(1);
                    end
                end
            end
            S_EMPTY_FWD:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{direction: 1'b0, element: '0, list_empty: 1'b1,
                                          end_of_direction: 1'b1, last: 1'b0,
                                          push_dropped: drop_reg};
                    state_next        = S_EMPTY_REV;
                end
            end
            S_EMPTY_REV:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{direction: 1'b1, element: '0, list_empty: 1'b1,
                                          end_of_direction: 1'b1, last: 1'b1,
                                          push_dropped: drop_reg};
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            drop_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            drop_reg         <= drop_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
